@@ rtl/core/vdf_pkg.sv @@
// shared constants for the variable delay line with feedback
`default_nettype none

package vdf_pkg;

  // defaults for the top-level parameters
  localparam int DEPTH_DEF          = 4096;
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int GAIN_FRAC_BITS_DEF = 14;

  // fixed field widths
  localparam int GAIN_WIDTH  = 16;
  localparam int DELAY_WIDTH = 12;

endpackage

`default_nettype wire

@@ rtl/core/variable_delay_with_feedback.sv @@
// variable delay line with feedback: ring memory, three-stage sample pipeline, output queue
//
//  channel    dir  handshake                      content
//  s_axis     in   s_axis_tvalid / s_axis_tready  sample, delay, gain, feedback delay; tlast
//  m_axis     out  m_axis_tvalid / m_axis_tready  delayed sample; tlast
//  cfg        in   cfg_wr_en                      max_delay
//
// a new sample is taken only once the last one has left stage b and the output queue has room; the single write port of
// the ring memory sets the first limit, since each sample writes the ring twice (input, feedback)
// a result passes stage b, stage c and the output queue registers before it reaches m_axis
// after reset all DEPTH ring entries (4096 by default) are zeroed with s_axis_tready low;
// configuration writes are taken during that sweep
// the two-entry output queue lets the pipeline run on while a result waits to be taken
`default_nettype none

module variable_delay_with_feedback
  import vdf_pkg::*;
#(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // sample_in, delay_req, feedback_gain, feedback_delay (lowest bits first)
  input  logic [((SAMPLE_WIDTH+2*DELAY_WIDTH+GAIN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic                                 s_axis_tlast,
  // sample_out
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_wr_en,
  input  logic [DELAY_WIDTH-1:0]               cfg_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW + 1 > DELAY_WIDTH) ? AW + 1 : DELAY_WIDTH;
  localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH + 1;
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam logic signed [PW-1:0] RND = PW'(1) << (GAIN_FRAC_BITS - 1);

  // field offsets inside s_axis_tdata
  localparam int DREQ_LO = SAMPLE_WIDTH;
  localparam int GAIN_LO = DREQ_LO + DELAY_WIDTH;
  localparam int FDEL_LO = GAIN_LO + GAIN_WIDTH;

  // configuration
  logic [DELAY_WIDTH-1:0] max_delay;

  // ring control
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // ram ports
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  // accept stage (combinational on the input beat)
  logic                    accept;
  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic [DELAY_WIDTH-1:0]  in_dreq;
  logic [GAIN_WIDTH-1:0]   in_gain;
  logic [DELAY_WIDTH-1:0]  in_fdel;
  logic [CW-1:0]           dly_x;
  logic [CW-1:0]           fdel_x;
  logic [AW-1:0]           dly_a;
  logic [AW-1:0]           fdel_a;
  logic [AW:0]             tail_w;
  logic [AW-1:0]           tail_a;
  logic                    fwd_c_a;

  // stage b: tail data back, multiply, feed address, sample write
  logic                    b_valid;
  logic [SAMPLE_WIDTH-1:0] b_sample;
  logic [GAIN_WIDTH-1:0]   b_gain;
  logic [AW-1:0]           b_fdel;
  logic [AW-1:0]           b_tail;
  logic [AW-1:0]           b_head;
  logic                    b_last;
  logic                    b_self;
  logic                    b_fromc;
  logic [SAMPLE_WIDTH-1:0] b_fwd_val;
  logic [SAMPLE_WIDTH-1:0] s_b;
  logic signed [SAMPLE_WIDTH-1:0] s_bs;
  logic signed [GAIN_WIDTH-1:0]   g_bs;
  logic signed [PW-1:0]    prod_b;
  logic [AW:0]             feed_w;
  logic [AW-1:0]           feed_b;

  // stage c: feed data back, accumulate, write back, push result
  logic                    c_valid;
  logic signed [PW-1:0]    c_prodr;
  logic [AW-1:0]           c_feed;
  logic                    c_feed_self;
  logic [SAMPLE_WIDTH-1:0] c_sample;
  logic [SAMPLE_WIDTH-1:0] c_s;
  logic                    c_same;
  logic                    c_last;
  logic [SAMPLE_WIDTH-1:0] c_acc;
  logic [SAMPLE_WIDTH-1:0] c_new;
  logic [SAMPLE_WIDTH-1:0] c_out;

  // output queue
  logic [SAMPLE_WIDTH-1:0] ob_data [2];
  logic                    ob_last [2];
  logic                    ob_wp;
  logic                    ob_rp;
  logic [1:0]              ob_count;
  logic                    pop;
  logic [1:0]              in_flight;

  assign in_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign in_dreq   = s_axis_tdata[DREQ_LO +: DELAY_WIDTH];
  assign in_gain   = s_axis_tdata[GAIN_LO +: GAIN_WIDTH];
  assign in_fdel   = s_axis_tdata[FDEL_LO +: DELAY_WIDTH];

  // room in the queue for everything already in flight plus this beat;
  // stage b must be empty so the two ring writes of neighbouring samples never collide
  assign in_flight     = ob_count + {1'b0, c_valid};
  assign s_axis_tready = !clearing && !b_valid && (in_flight < 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // delay clamps, then tail = head - delay around the ring
  always_comb begin
    dly_x = CW'(in_dreq);
    if (dly_x > CW'(max_delay)) begin
      dly_x = CW'(max_delay);
    end
    if (dly_x > CW'(DEPTH - 1)) begin
      dly_x = CW'(DEPTH - 1);
    end
    fdel_x = CW'(in_fdel);
    if (fdel_x > dly_x) begin
      fdel_x = dly_x;
    end
    dly_a  = dly_x[AW-1:0];
    fdel_a = fdel_x[AW-1:0];
    if (head >= dly_a) begin
      tail_w = {1'b0, head} - {1'b0, dly_a};
    end else begin
      tail_w = {1'b0, head} + (AW+1)'(DEPTH) - {1'b0, dly_a};
    end
    tail_a = tail_w[AW-1:0];
  end

  // the tail read overlaps the previous sample's feedback write
  assign fwd_c_a   = c_valid && (c_feed == tail_a);
  assign head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  // stage b datapath
  always_comb begin
    if (b_self) begin
      s_b = b_sample;
    end else if (b_fromc) begin
      s_b = b_fwd_val;
    end else begin
      s_b = ram_rdata;
    end
    s_bs   = s_b;
    g_bs   = b_gain;
    prod_b = PW'(s_bs) * PW'(g_bs) + RND;
    feed_w = {1'b0, b_tail} + {1'b0, b_fdel};
    if (feed_w >= (AW+1)'(DEPTH)) begin
      feed_w = feed_w - (AW+1)'(DEPTH);
    end
    feed_b = feed_w[AW-1:0];
  end

  // stage c datapath; the feed entry may be this sample's own head write
  assign c_acc = c_feed_self ? c_sample : ram_rdata;

  vdf_feedback #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_feedback (
    .prod   (c_prodr),
    .acc    (c_acc),
    .result (c_new)
  );

  assign c_out = c_same ? c_new : c_s;

  // ring memory ports: clearing sweep, then feedback write over sample write
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (c_valid) begin
      ram_we    = 1'b1;
      ram_waddr = c_feed;
      ram_wdata = c_new;
    end else begin
      ram_we    = b_valid;
      ram_waddr = b_head;
      ram_wdata = b_sample;
    end
    ram_raddr = b_valid ? feed_b : tail_a;
  end

  vdf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= '0;
      head      <= '0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_delay <= cfg_wr_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        head <= head_next;
      end
      b_valid <= accept;
      c_valid <= b_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_sample  <= in_sample;
      b_gain    <= in_gain;
      b_fdel    <= fdel_a;
      b_tail    <= tail_a;
      b_head    <= head;
      b_last    <= s_axis_tlast;
      b_self    <= (dly_a == '0);
      b_fromc   <= fwd_c_a;
      b_fwd_val <= c_new;
    end
    if (b_valid) begin
      c_prodr     <= prod_b;
      c_feed      <= feed_b;
      c_feed_self <= (feed_b == b_head);
      c_sample    <= b_sample;
      c_s         <= s_b;
      c_same      <= (feed_b == b_tail);
      c_last      <= b_last;
    end
  end

  // output queue
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (ob_count != 2'd0);
  assign m_axis_tdata  = OUT_W'(ob_data[ob_rp]);
  assign m_axis_tlast  = ob_last[ob_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wp    <= 1'b0;
      ob_rp    <= 1'b0;
      ob_count <= 2'd0;
    end else begin
      if (c_valid) begin
        ob_wp <= ~ob_wp;
      end
      if (pop) begin
        ob_rp <= ~ob_rp;
      end
      ob_count <= ob_count + {1'b0, c_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid) begin
      ob_data[ob_wp] <= c_out;
      ob_last[ob_wp] <= c_last;
    end
  end

`ifndef ASSERT_OFF
  // two ring writes in one cycle would be lost
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(b_valid && c_valid))
    else $error("stages b and c both busy");

  // the queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (ob_count != 2'd3) && !(c_valid && ob_count == 2'd2 && !pop))
    else $error("output queue overflow");

  // every accepted beat passes stage b and then reaches the accumulate stage
  a_accept_to_c: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 c_valid)
    else $error("accepted beat lost in pipeline");

  // no beat while the ring is being zeroed
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("beat taken during clearing sweep");
`endif

endmodule

`default_nettype wire

@@ rtl/core/vdf_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module vdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/vdf_feedback.sv @@
// feedback scaling, accumulation and saturation
`default_nettype none

module vdf_feedback
  import vdf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic signed [SAMPLE_WIDTH+GAIN_WIDTH:0] prod,
  input  logic signed [SAMPLE_WIDTH-1:0]          acc,
  output logic signed [SAMPLE_WIDTH-1:0]          result
);

  localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH + 1;

  localparam logic signed [PW-1:0] SMAX =
    {{(PW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN =
    {{(PW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] fb;
  logic signed [PW-1:0] sum;

  always_comb begin
    // floor of the rounded product over the gain scale
    fb  = prod >>> GAIN_FRAC_BITS;
    sum = PW'(acc) + fb;
    if (sum > SMAX) begin
      result = SMAX[SAMPLE_WIDTH-1:0];
    end else if (sum < SMIN) begin
      result = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      result = sum[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire
